FILE: hdl/ahdbp_pkg.sv
// shared types and constants for the ascii hex / decimal byte parser
// no dependencies; used by every other file of the block except ahdbp_if
`default_nettype none

package ahdbp_pkg;

   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [9:0] BYTE_MAX   = 10'd255;

   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_SYNTAX = 2'd1,
      KIND_RANGE  = 2'd2,
      KIND_END    = 2'd3
   } kind_type;

   typedef enum logic [5:0] {
      PH_IDLE    = 6'b000001,
      PH_HEX1    = 6'b000010,
      PH_DEC1    = 6'b000100,
      PH_DEC2    = 6'b001000,
      PH_COMMENT = 6'b010000,
      PH_DONE    = 6'b100000
   } phase_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] byte_value;
      logic       run_last;
   } result_type;

   // all results caused by one character
   typedef struct packed {
      logic [1:0]                   count;
      result_type [MAX_RESULTS-1:0] slot;
   } group_type;

   typedef struct packed {
      group_type  group;
      phase_type  phase;
      logic [7:0] partial;
   } decode_type;

endpackage

`default_nettype wire

FILE: hdl/ahdbp_if.sv
// valid/ready channel interfaces for characters in and results out
// depends on nothing; field widths follow the block's payload
`default_nettype none

interface ahdbp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_char;
   logic       end_of_text;

   modport source (output valid, output text_char, output end_of_text, input ready);
   modport sink (input valid, input text_char, input end_of_text, output ready);
endinterface

interface ahdbp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] byte_value;
   logic       run_last;

   modport source (output valid, output kind, output byte_value, output run_last,
                   input ready);
   modport sink (input valid, input kind, input byte_value, input run_last,
                 output ready);
endinterface

`default_nettype wire

FILE: hdl/ascii_hex_decimal_byte_parser.sv
// top level of the ascii hex / decimal byte parser
// depends on ahdbp_pkg, ahdbp_if, ahdbp_decode and ahdbp_queue
`default_nettype none

// Decodes one text character per req beat into data bytes, error results and
// an end result per stream; csr_wr_data selects hex pairs (0) or decimal (1).
// The combinational decode and the parse state update sit between the req beat
// and a four-entry result queue, whose registers hold the results until rsp
// takes them. The queue hands out one result per cycle while rsp is ready; req
// is taken whenever the queue holds at most one result, which gives one
// character per cycle while each character yields at most one result and rsp
// is ready.

module ascii_hex_decimal_byte_parser (
   input  wire          clock,
   input  wire          reset,
   input  wire          csr_wr_en,
   input  wire          csr_wr_data,
   ahdbp_req_if.sink    req_ch,
   ahdbp_rsp_if.source  rsp_ch
);

   ahdbp_pkg::phase_type  phase_ff;
   logic [7:0]            partial_ff;
   logic                  mode_ff;
   ahdbp_pkg::decode_type decode;
   logic                  room;
   logic                  take;

   assign req_ch.ready = room;
   assign take         = req_ch.valid && room;

   ahdbp_decode u_decode (
      .decimal_mode (mode_ff),
      .phase        (phase_ff),
      .partial      (partial_ff),
      .text_char    (req_ch.text_char),
      .end_of_text  (req_ch.end_of_text),
      .decode       (decode)
   );

   ahdbp_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (take),
      .group  (decode.group),
      .room   (room),
      .rsp_ch (rsp_ch)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= ahdbp_pkg::PH_IDLE;
         partial_ff <= '0;
         mode_ff    <= 1'b0;
      end else begin
         if (take) begin
            phase_ff   <= decode.phase;
            partial_ff <= decode.partial;
         end
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
   end

endmodule

`default_nettype wire

FILE: hdl/ahdbp_decode.sv
// one-character decode step: results of the character and next parse state
// depends on ahdbp_pkg
`default_nettype none

module ahdbp_decode (
   input  wire                    decimal_mode,
   input  ahdbp_pkg::phase_type   phase,
   input  wire [7:0]              partial,
   input  wire [7:0]              text_char,
   input  wire                    end_of_text,
   output ahdbp_pkg::decode_type  decode
);

   always_comb begin
      logic [1:0]           cnt;
      ahdbp_pkg::group_type grp;
      ahdbp_pkg::phase_type ph;
      logic [7:0]           pv;
      logic                 dispatch;
      logic                 is_dec;
      logic                 is_hex;
      logic                 is_sep;
      logic [3:0]           hv;
      logic [9:0]           tsum;

      cnt      = 2'd0;
      grp      = '0;
      ph       = phase;
      pv       = partial;
      dispatch = 1'b0;
      tsum     = '0;

      is_dec = text_char inside {[8'h30:8'h39]};
      is_hex = is_dec || (text_char inside {[8'h41:8'h46], [8'h61:8'h66]});
      is_sep = (text_char inside {8'h20, [8'h09:8'h0D]}) || text_char == ahdbp_pkg::CHAR_COMMA;
      if (is_dec) begin
         hv = text_char[3:0];
      end else begin
         hv = text_char[3:0] + 4'd9;
      end

      case (phase)
         ahdbp_pkg::PH_DONE: begin
         end
         ahdbp_pkg::PH_COMMENT: begin
            if (text_char == ahdbp_pkg::CHAR_LF) begin
               ph = ahdbp_pkg::PH_IDLE;
            end else if (text_char == ahdbp_pkg::CHAR_NUL) begin
               ph = ahdbp_pkg::PH_DONE;
            end
         end
         ahdbp_pkg::PH_HEX1: begin
            if (is_hex) begin
               grp.slot[cnt] = '{ahdbp_pkg::KIND_DATA, {pv[3:0], hv}, 1'b0};
               cnt = cnt + 2'd1;
               pv  = '0;
               ph  = ahdbp_pkg::PH_IDLE;
            end else begin
               grp.slot[cnt] = '{ahdbp_pkg::KIND_DATA, pv, 1'b0};
               cnt      = cnt + 2'd1;
               pv       = '0;
               dispatch = 1'b1;
            end
         end
         ahdbp_pkg::PH_DEC1: begin
            if (is_dec) begin
               // pv holds one digit here, so the sum stays below 100
               pv = (pv << 3) + (pv << 1) + {4'd0, text_char[3:0]};
               ph = ahdbp_pkg::PH_DEC2;
            end else begin
               grp.slot[cnt] = '{ahdbp_pkg::KIND_DATA, pv, 1'b0};
               cnt      = cnt + 2'd1;
               pv       = '0;
               dispatch = 1'b1;
            end
         end
         ahdbp_pkg::PH_DEC2: begin
            if (is_dec) begin
               tsum = ({2'd0, pv} << 3) + ({2'd0, pv} << 1) + {6'd0, text_char[3:0]};
               pv   = '0;
               if (tsum > ahdbp_pkg::BYTE_MAX) begin
                  grp.slot[cnt] = '{ahdbp_pkg::KIND_RANGE, 8'd0, 1'b0};
                  ph = ahdbp_pkg::PH_DONE;
               end else begin
                  grp.slot[cnt] = '{ahdbp_pkg::KIND_DATA, tsum[7:0], 1'b0};
                  ph = ahdbp_pkg::PH_IDLE;
               end
               cnt = cnt + 2'd1;
            end else begin
               grp.slot[cnt] = '{ahdbp_pkg::KIND_DATA, pv, 1'b0};
               cnt      = cnt + 2'd1;
               pv       = '0;
               dispatch = 1'b1;
            end
         end
         default: begin
            dispatch = 1'b1;
         end
      endcase

      // start of a new token
      if (dispatch) begin
         ph = ahdbp_pkg::PH_IDLE;
         if (text_char == ahdbp_pkg::CHAR_NUL) begin
            ph = ahdbp_pkg::PH_DONE;
         end else if (text_char == ahdbp_pkg::CHAR_HASH) begin
            ph = ahdbp_pkg::PH_COMMENT;
         end else if (is_sep) begin
            ph = ahdbp_pkg::PH_IDLE;
         end else if (decimal_mode ? is_dec : is_hex) begin
            pv = {4'd0, hv};
            ph = decimal_mode ? ahdbp_pkg::PH_DEC1 : ahdbp_pkg::PH_HEX1;
         end else begin
            grp.slot[cnt] = '{ahdbp_pkg::KIND_SYNTAX, 8'd0, 1'b0};
            cnt = cnt + 2'd1;
            ph  = ahdbp_pkg::PH_DONE;
         end
      end

      if (end_of_text) begin
         if (ph == ahdbp_pkg::PH_HEX1 || ph == ahdbp_pkg::PH_DEC1 ||
             ph == ahdbp_pkg::PH_DEC2) begin
            grp.slot[cnt] = '{ahdbp_pkg::KIND_DATA, pv, 1'b0};
            cnt = cnt + 2'd1;
         end
         grp.slot[cnt] = '{ahdbp_pkg::KIND_END, 8'd0, 1'b0};
         cnt = cnt + 2'd1;
         ph  = ahdbp_pkg::PH_IDLE;
         pv  = '0;
      end

      grp.count      = cnt;
      decode.group   = grp;
      decode.phase   = ph;
      decode.partial = pv;
   end

endmodule

`default_nettype wire

FILE: hdl/ahdbp_queue.sv
// result queue: takes a whole group of results per beat, hands out one per beat
// depends on ahdbp_pkg and ahdbp_rsp_if
`default_nettype none

module ahdbp_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  ahdbp_pkg::group_type group,
   output logic                 room,
   ahdbp_rsp_if.source          rsp_ch
);

   ahdbp_pkg::result_type [ahdbp_pkg::QUEUE_DEPTH-1:0] q_ff, q_in;
   logic [ahdbp_pkg::COUNT_W-1:0]                      count_ff, count_in;
   logic [ahdbp_pkg::COUNT_W-1:0]                      cnt_pop;
   logic                                               pop;
   logic [ahdbp_pkg::COUNT_W-1:0]                      push_n;

   assign pop    = rsp_ch.valid && rsp_ch.ready;
   assign push_n = push ? ahdbp_pkg::COUNT_W'(group.count) : '0;

   // room for a full group even while one result still waits
   assign room = count_ff <= ahdbp_pkg::COUNT_W'(ahdbp_pkg::QUEUE_DEPTH - ahdbp_pkg::MAX_RESULTS);

   assign rsp_ch.valid      = count_ff != '0;
   assign rsp_ch.kind       = q_ff[0].kind;
   assign rsp_ch.byte_value = q_ff[0].byte_value;
   assign rsp_ch.run_last   = q_ff[0].run_last;

   assign cnt_pop  = count_ff - ahdbp_pkg::COUNT_W'(pop);
   assign count_in = cnt_pop + push_n;

   always_comb begin
      for (int j = 0; j < ahdbp_pkg::QUEUE_DEPTH; j++) begin
         if (pop && j < ahdbp_pkg::QUEUE_DEPTH - 1) begin
            q_in[j] = q_ff[j + 1];
         end else begin
            q_in[j] = q_ff[j];
         end
         for (int i = 0; i < ahdbp_pkg::MAX_RESULTS; i++) begin
            if (ahdbp_pkg::COUNT_W'(i) < push_n &&
                ahdbp_pkg::COUNT_W'(j) == cnt_pop + ahdbp_pkg::COUNT_W'(i)) begin
               q_in[j]          = group.slot[i];
               q_in[j].run_last = ahdbp_pkg::COUNT_W'(i + 1) == push_n;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      q_ff <= q_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ahdbp_pkg::COUNT_W'(ahdbp_pkg::QUEUE_DEPTH))
      else $error("result queue over capacity");

   a_group_whole: assert property (@(posedge clock) disable iff (reset)
      (pop && !q_ff[0].run_last) |-> count_ff >= ahdbp_pkg::COUNT_W'(2))
      else $error("result group split in queue");

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      (push_n != '0) |-> (int'(count_ff) + int'(push_n) <= ahdbp_pkg::QUEUE_DEPTH))
      else $error("group pushed without room");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && push_n == '0) |=> count_ff == $past(count_ff) - ahdbp_pkg::COUNT_W'(1))
      else $error("queue count lost a pop");

endmodule

`default_nettype wire

FILE: tb/sv/ascii_hex_decimal_byte_parser_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for ascii_hex_decimal_byte_parser: directed and random text streams
// depends on ahdbp_pkg, ahdbp_if and the parser top level; holds its own parser predictor

module ascii_hex_decimal_byte_parser_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int RANDOM_ITEMS = 170;
   localparam int MAX_PRINTS   = 60;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   ahdbp_req_if req_ch ();
   ahdbp_rsp_if rsp_ch ();

   ascii_hex_decimal_byte_parser dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // predictor state
   ahdbp_pkg::phase_type pred_phase   = ahdbp_pkg::PH_IDLE;
   logic [7:0]           pred_value   = 8'd0;
   logic                 pred_decimal = 1'b0;

   ahdbp_pkg::result_type want_results [$];
   logic [7:0]            stream_chars [$];

   int req_idle_max    = 3;
   int rsp_idle_max    = 3;
   int error_count     = 0;
   int sent_items      = 0;
   int live_items      = 0;
   int results_checked = 0;
   int streams_sent    = 0;
   int mode_writes     = 0;
   int cycle_count     = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  want_results.size());
         $display("status: fail");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTS)
         $display("mismatch at %0t: %s", $time, what);
   endtask

   function automatic int hex_digit(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - 8'h30);
      if (c >= "A" && c <= "F") return int'(c - 8'h41) + 10;
      if (c >= "a" && c <= "f") return int'(c - 8'h61) + 10;
      return -1;
   endfunction

   function automatic logic is_dec(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic ahdbp_pkg::result_type mk_result(input ahdbp_pkg::kind_type k,
                                                       input logic [7:0] v);
      ahdbp_pkg::result_type r;
      r.kind       = k;
      r.byte_value = v;
      r.run_last   = 1'b0;
      return r;
   endfunction

   // advances the predictor by one character and queues the results it causes
   task automatic decode_char(input logic [7:0] c, input logic eot);
      ahdbp_pkg::result_type got [$];
      int                    hv;
      int                    sum;
      logic                  start_new;
      hv        = hex_digit(c);
      start_new = 1'b0;
      case (pred_phase)
         ahdbp_pkg::PH_DONE: ;
         ahdbp_pkg::PH_COMMENT: begin
            if (c == ahdbp_pkg::CHAR_LF) pred_phase = ahdbp_pkg::PH_IDLE;
            else if (c == ahdbp_pkg::CHAR_NUL) pred_phase = ahdbp_pkg::PH_DONE;
         end
         ahdbp_pkg::PH_HEX1: begin
            if (hv >= 0) begin
               got.push_back(mk_result(ahdbp_pkg::KIND_DATA, {pred_value[3:0], 4'(hv)}));
               pred_value = 8'd0;
               pred_phase = ahdbp_pkg::PH_IDLE;
            end else begin
               got.push_back(mk_result(ahdbp_pkg::KIND_DATA, pred_value));
               pred_value = 8'd0;
               start_new  = 1'b1;
            end
         end
         ahdbp_pkg::PH_DEC1: begin
            if (is_dec(c)) begin
               pred_value = pred_value * 8'd10 + (c - 8'h30);
               pred_phase = ahdbp_pkg::PH_DEC2;
            end else begin
               got.push_back(mk_result(ahdbp_pkg::KIND_DATA, pred_value));
               pred_value = 8'd0;
               start_new  = 1'b1;
            end
         end
         ahdbp_pkg::PH_DEC2: begin
            if (is_dec(c)) begin
               sum        = int'(pred_value) * 10 + int'(c - 8'h30);
               pred_value = 8'd0;
               if (sum > int'(ahdbp_pkg::BYTE_MAX)) begin
                  got.push_back(mk_result(ahdbp_pkg::KIND_RANGE, 8'd0));
                  pred_phase = ahdbp_pkg::PH_DONE;
               end else begin
                  got.push_back(mk_result(ahdbp_pkg::KIND_DATA, 8'(sum)));
                  pred_phase = ahdbp_pkg::PH_IDLE;
               end
            end else begin
               got.push_back(mk_result(ahdbp_pkg::KIND_DATA, pred_value));
               pred_value = 8'd0;
               start_new  = 1'b1;
            end
         end
         default: start_new = 1'b1;
      endcase

      if (start_new) begin
         pred_phase = ahdbp_pkg::PH_IDLE;
         if (c == ahdbp_pkg::CHAR_NUL) begin
            pred_phase = ahdbp_pkg::PH_DONE;
         end else if (c == ahdbp_pkg::CHAR_HASH) begin
            pred_phase = ahdbp_pkg::PH_COMMENT;
         end else if (is_blank(c) || c == ahdbp_pkg::CHAR_COMMA) begin
            pred_phase = ahdbp_pkg::PH_IDLE;
         end else if (pred_decimal && is_dec(c)) begin
            pred_value = c - 8'h30;
            pred_phase = ahdbp_pkg::PH_DEC1;
         end else if (!pred_decimal && hv >= 0) begin
            pred_value = 8'(hv);
            pred_phase = ahdbp_pkg::PH_HEX1;
         end else begin
            got.push_back(mk_result(ahdbp_pkg::KIND_SYNTAX, 8'd0));
            pred_phase = ahdbp_pkg::PH_DONE;
         end
      end

      if (eot) begin
         if (pred_phase == ahdbp_pkg::PH_HEX1 || pred_phase == ahdbp_pkg::PH_DEC1 ||
             pred_phase == ahdbp_pkg::PH_DEC2)
            got.push_back(mk_result(ahdbp_pkg::KIND_DATA, pred_value));
         got.push_back(mk_result(ahdbp_pkg::KIND_END, 8'd0));
         pred_phase = ahdbp_pkg::PH_IDLE;
         pred_value = 8'd0;
      end

      if (got.size() > 0) got[got.size() - 1].run_last = 1'b1;
      foreach (got[i]) want_results.push_back(got[i]);
   endtask

   task automatic send_char(input logic [7:0] c, input logic eot);
      int gap;
      gap = $urandom_range(0, req_idle_max);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.text_char   <= c;
      req_ch.end_of_text <= eot;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sent_items++;
      if (pred_phase != ahdbp_pkg::PH_DONE) live_items++;
      decode_char(c, eot);
   endtask

   task automatic send_text(input string s, input logic eot_at_end);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], eot_at_end && i == s.len() - 1);
   endtask

   // a character that causes no result may still be in flight, so keep waiting after the last expected result
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (want_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_mode(input logic decimal);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= decimal;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      pred_decimal = decimal;
      mode_writes++;
   endtask

   function automatic logic [7:0] rand_hex_char();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'h30 + 8'(v);
      return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v - 10);
   endfunction

   // mostly well-formed tokens in the current mode, with comments and some noise
   task automatic build_stream();
      logic [7:0] blanks [7] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D,
                                 ahdbp_pkg::CHAR_COMMA};
      int         tokens;
      int         n;
      logic [7:0] c;
      stream_chars.delete();
      tokens = $urandom_range(1, 10);
      for (int t = 0; t < tokens; t++) begin
         case ($urandom_range(0, 11))
            0: stream_chars.push_back(8'($urandom_range(0, 255)));
            1: begin
               stream_chars.push_back(ahdbp_pkg::CHAR_HASH);
               n = $urandom_range(0, 4);
               repeat (n) begin
                  c = 8'($urandom_range(1, 255));
                  if (c == ahdbp_pkg::CHAR_LF) c = "x";
                  stream_chars.push_back(c);
               end
               stream_chars.push_back(ahdbp_pkg::CHAR_LF);
            end
            default: begin
               if (pred_decimal) begin
                  n = $urandom_range(1, 3);
                  // keep most three digit values in range
                  if (n == 3 && $urandom_range(0, 7) != 0)
                     stream_chars.push_back(8'h30 + 8'($urandom_range(0, 2)));
                  else
                     stream_chars.push_back(8'h30 + 8'($urandom_range(0, 9)));
                  repeat (n - 1) stream_chars.push_back(8'h30 + 8'($urandom_range(0, 9)));
               end else begin
                  n = $urandom_range(1, 2);
                  repeat (n) stream_chars.push_back(rand_hex_char());
               end
            end
         endcase
         if ($urandom_range(0, 3) != 0) stream_chars.push_back(blanks[$urandom_range(0, 6)]);
      end
   endtask

   task automatic send_stream();
      int cut;
      cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, stream_chars.size()) : 0;
      foreach (stream_chars[i]) begin
         if (cut != 0 && i == cut) set_mode(!pred_decimal);
         send_char(stream_chars[i], i == stream_chars.size() - 1);
      end
      streams_sent++;
   endtask

   task automatic test_hex_tokens();
      set_mode(1'b0);
      // pair, lone digit ended by tab, lone digit ended by comma on the last char
      send_text("ff 0\ta,", 1'b1);
   endtask

   task automatic test_comments();
      send_text("#x\n7", 1'b1);
      // nul inside a comment stops parsing, the rest is ignored until end of text
      send_text("#", 1'b0);
      send_char(ahdbp_pkg::CHAR_NUL, 1'b0);
      send_text("Z", 1'b1);
   endtask

   task automatic test_syntax_errors();
      send_char(8'hFF, 1'b1);
      // pending digit, then error, then end: three results on one beat
      send_text("3G", 1'b1);
   endtask

   task automatic test_mode_switch();
      set_mode(1'b0);
      send_text("A", 1'b0);
      // pending hex token finishes under hex rules after the switch
      set_mode(1'b1);
      send_text("b12", 1'b1);
   endtask

   task automatic test_decimal_tokens();
      set_mode(1'b1);
      // 255, then a new token 256 that is out of range, then ignored until end
      send_text("2552560", 1'b1);
   endtask

   task automatic test_random_streams();
      int start_sent;
      start_sent = sent_items;
      while (sent_items - start_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) == 0) set_mode(1'($urandom_range(0, 1)));
         req_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
         rsp_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
         build_stream();
         send_stream();
      end
   endtask

   // result checker
   initial begin
      ahdbp_pkg::result_type want;
      int                    stall;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         stall = $urandom_range(0, rsp_idle_max);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         if (want_results.size() == 0) begin
            report_mismatch($sformatf("unexpected beat kind %0d byte %02h last %0b",
                                      rsp_ch.kind, rsp_ch.byte_value, rsp_ch.run_last));
         end else begin
            want = want_results.pop_front();
            results_checked++;
            if (rsp_ch.kind !== want.kind)
               report_mismatch($sformatf("kind %0d, expected %0d", rsp_ch.kind, want.kind));
            if (rsp_ch.byte_value !== want.byte_value)
               report_mismatch($sformatf("byte %02h, expected %02h", rsp_ch.byte_value,
                                         want.byte_value));
            if (rsp_ch.run_last !== want.run_last)
               report_mismatch($sformatf("run_last %0b, expected %0b", rsp_ch.run_last,
                                         want.run_last));
         end
      end
   end

   initial begin
      int drain_cycles;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = 1'b0;
      req_ch.valid       = 1'b0;
      req_ch.text_char   = 8'd0;
      req_ch.end_of_text = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_hex_tokens();
      test_comments();
      test_syntax_errors();
      test_mode_switch();
      test_decimal_tokens();
      test_random_streams();

      req_ch.valid <= 1'b0;
      drain_cycles = 0;
      while (want_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (8) @(posedge clock);
      if (want_results.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   want_results.size()));

      $display("sent %0d characters (%0d parsed) in %0d random streams plus directed text",
               sent_items, live_items, streams_sent);
      $display("checked %0d results, %0d mode writes, %0d mismatches", results_checked,
               mode_writes, error_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
